// ===== rtl/pkdp_pkg.sv =====
// Shared types and constants for the particle kick/drift update block.
// Holds the back-end state encoding, the queue control struct and register indexes.
// No dependencies.
package pkdp_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_FACTOR = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERIODIC    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_X_LOW   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_X_HIGH  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_Y_LOW   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_Y_HIGH  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_Z_LOW   = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_Z_HIGH  = 3'd7;

    localparam int AXES        = 3;
    localparam int QUEUE_DEPTH = 2;

    // Largest squared step is a 64-bit saturating value; its root has 32 bits
    localparam int SQ_BITS        = 64;
    localparam int ROOT_BITS      = SQ_BITS / 2;
    localparam int ROOT_CNT_BITS  = $clog2(ROOT_BITS);

    typedef enum logic [1:0] {
        S_MUL,
        S_SQ,
        S_FIN,
        S_ROOT
    } t_state;

    typedef struct packed {
        logic drift;
        logic last;
    } t_item_ctl;

endpackage

// ===== rtl/pkdp_front.sv =====
// Front end: takes particle words from the input stream and sorts out what the back end needs.
// Picks the multiplicand and the base word per axis and splits the multiplicand into sign/magnitude.
// Depends on pkdp_pkg.
module pkdp_front #(
    parameter int WORD_BITS = 32,
    parameter int IN_BITS   = ((9 * WORD_BITS + 7) / 8) * 8,
    parameter int PAY_BITS  = 6 * WORD_BITS + 3
) (
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_BITS-1:0]   i_s_tdata,   // pos_x,y,z, vel_x,y,z, acc_x,y,z, zero pad
    input  logic                 i_s_tuser,   // operation
    input  logic                 i_s_tlast,   // last_particle
    input  logic                 i_q_full,
    output logic                 o_push,
    output pkdp_pkg::t_item_ctl  o_ctl,
    output logic [PAY_BITS-1:0]  o_payload
);
    import pkdp_pkg::*;

    localparam int W = WORD_BITS;

    logic [W-1:0] pos [AXES];
    logic [W-1:0] vel [AXES];
    logic [W-1:0] acc [AXES];
    logic [W-1:0] mul_op [AXES];

    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full;
    assign o_ctl.drift = i_s_tuser;
    assign o_ctl.last  = i_s_tlast;

    // payload: base words, then multiplicand magnitudes, then their signs
    always_comb begin
        o_payload = '0;
        for (int k = 0; k < AXES; k++) begin
            pos[k]    = i_s_tdata[k*W +: W];
            vel[k]    = i_s_tdata[(AXES+k)*W +: W];
            acc[k]    = i_s_tdata[(2*AXES+k)*W +: W];
            mul_op[k] = i_s_tuser ? vel[k] : acc[k];
            o_payload[k*W +: W]        = i_s_tuser ? pos[k] : vel[k];
            o_payload[(AXES+k)*W +: W] = mul_op[k][W-1] ? (~mul_op[k] + 1'b1) : mul_op[k];
            o_payload[2*AXES*W + k]    = mul_op[k][W-1];
        end
    end

endmodule

// ===== rtl/pkdp_queue.sv =====
// Short register queue between the front end and the back end.
// Lets either side stall on its own; depth from pkdp_pkg.
// Depends on pkdp_pkg.
module pkdp_queue #(
    parameter int DATA_BITS = 200
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_data,
    output logic                 o_full,
    output logic                 o_valid,
    output logic [DATA_BITS-1:0] o_data,
    input  logic                 i_pop
);
    import pkdp_pkg::*;

    localparam int PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntBits = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_BITS-1:0] r_slot [QUEUE_DEPTH];
    logic [PtrBits-1:0]   r_wr, n_wr;
    logic [PtrBits-1:0]   r_rd, n_rd;
    logic [CntBits-1:0]   r_count, n_count;
    logic                 do_pop;

    assign o_full  = (r_count == CntBits'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntBits'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("word pushed into a full queue");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !i_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop without push did not drain the queue");

endmodule

// ===== rtl/pkdp_back.sv =====
// Back end: multiplies, saturates, wraps and tracks the largest squared step.
// Holds the configuration registers, the bit-serial square root and the output register.
// Depends on pkdp_pkg.
module pkdp_back #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16,
    parameter int PAY_BITS  = 6 * WORD_BITS + 3,
    parameter int OUT_BITS  = ((4 * WORD_BITS + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pkdp_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [WORD_BITS-1:0]               i_cfg_data,
    input  logic                               i_q_valid,
    output logic                               o_q_pop,
    input  pkdp_pkg::t_item_ctl                i_q_ctl,
    input  logic [PAY_BITS-1:0]                i_q_payload,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [OUT_BITS-1:0]                o_m_tdata,  // new_x,y,z, max_step, zero pad
    output logic                               o_m_tuser,  // out_of_box
    output logic                               o_m_tlast   // pass_done
);
    import pkdp_pkg::*;

    localparam int W       = WORD_BITS;
    localparam int W2      = 2 * WORD_BITS;
    localparam int ExtBits = (W2 + 2 > SQ_BITS) ? W2 + 2 : SQ_BITS;
    localparam int ExtR    = (W > ROOT_BITS) ? W : ROOT_BITS;

    localparam logic [W-1:0] WMaxU  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WHalfU = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W+1:0] EMax = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] EMin = {3'b111, {(W-1){1'b0}}};
    localparam logic [W-1:0] OneQ   = W'(1) << FRAC_BITS;

    // configuration
    logic signed [W-1:0] r_step;
    logic                r_periodic;
    logic signed [W-1:0] r_box_low  [AXES];
    logic signed [W-1:0] r_box_high [AXES];
    logic [W-1:0]        r_ms;
    logic                r_sneg;
    logic signed [W+1:0] r_span  [AXES];
    logic                r_empty [AXES];

    // sequencer and datapath registers
    t_state              r_state, n_state;
    t_item_ctl           r_ctl;
    logic signed [W-1:0] r_base [AXES];
    logic                r_neg  [AXES];
    logic [W2-1:0]       r_p    [AXES];
    logic signed [W-1:0] r_sum  [AXES];
    logic [W2-1:0]       r_sq   [AXES];
    logic [SQ_BITS-1:0]  r_max;
    logic signed [W-1:0] r_res  [AXES];
    logic                r_roob;

    // square root
    logic [SQ_BITS-1:0]       r_rad;
    logic [ROOT_BITS+1:0]     r_rem;
    logic [ROOT_BITS-1:0]     r_root;
    logic [ROOT_CNT_BITS-1:0] r_cnt;
    logic                     r_rdone;

    // output register
    logic                r_out_valid;
    logic [W-1:0]        r_out_new [AXES];
    logic [W-1:0]        r_out_max;
    logic                r_out_last;
    logic                r_out_oob;

    // combinational datapath
    logic [W-1:0]        q_base [AXES];
    logic [W-1:0]        q_mag  [AXES];
    logic                q_neg  [AXES];
    logic [W2-1:0]       prod   [AXES];
    logic [W2-1:0]       m_sh   [AXES];
    logic [W-1:0]        lim    [AXES];
    logic [W-1:0]        md     [AXES];
    logic [W-1:0]        d      [AXES];
    logic [W2-1:0]       md_sq  [AXES];
    logic signed [W:0]   add_s  [AXES];
    logic signed [W-1:0] add_c  [AXES];
    logic signed [W+1:0] s_e, lo_e, hi_e, t_e;
    logic signed [W-1:0] p_w    [AXES];
    logic                outside [AXES];
    logic signed [W-1:0] res    [AXES];
    logic                wrap_on;
    logic                oob;
    logic [ExtBits-1:0]  sq_sum;
    logic [SQ_BITS-1:0]  sq64;
    logic [SQ_BITS-1:0]  max_new;
    logic [ROOT_BITS+3:0] rem_t, trial;
    logic                root_ge;
    logic [ExtR-1:0]     root_ext;
    logic [W-1:0]        root_out;

    // control
    logic out_free;
    logic q_pop, fin_emit, fin_root, root_step, root_emit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= OneQ;
            r_periodic <= 1'b0;
            for (int k = 0; k < AXES; k++) begin
                r_box_low[k]  <= '0;
                r_box_high[k] <= OneQ;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STEP_FACTOR: r_step        <= i_cfg_data;
                CFG_PERIODIC:    r_periodic    <= i_cfg_data[0];
                CFG_BOX_X_LOW:   r_box_low[0]  <= i_cfg_data;
                CFG_BOX_X_HIGH:  r_box_high[0] <= i_cfg_data;
                CFG_BOX_Y_LOW:   r_box_low[1]  <= i_cfg_data;
                CFG_BOX_Y_HIGH:  r_box_high[1] <= i_cfg_data;
                CFG_BOX_Z_LOW:   r_box_low[2]  <= i_cfg_data;
                CFG_BOX_Z_HIGH:  r_box_high[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // derived configuration, registered from the configuration registers
    always_ff @(posedge i_clk) begin
        r_sneg <= r_step[W-1];
        r_ms   <= r_step[W-1] ? (~r_step + 1'b1) : r_step;
        for (int k = 0; k < AXES; k++) begin
            r_span[k]  <= (W+2)'(r_box_high[k]) - (W+2)'(r_box_low[k]);
            r_empty[k] <= (r_box_high[k] <= r_box_low[k]);
        end
    end

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            q_base[k] = i_q_payload[k*W +: W];
            q_mag[k]  = i_q_payload[(AXES+k)*W +: W];
            q_neg[k]  = i_q_payload[2*AXES*W + k];
            prod[k]   = W2'(q_mag[k]) * W2'(r_ms);

            // truncate toward zero, saturate the step magnitude, then restore sign
            m_sh[k]  = r_p[k] >> FRAC_BITS;
            lim[k]   = r_neg[k] ? WHalfU : WMaxU;
            md[k]    = (m_sh[k] > W2'(lim[k])) ? lim[k] : m_sh[k][W-1:0];
            d[k]     = r_neg[k] ? (~md[k] + 1'b1) : md[k];
            md_sq[k] = W2'(md[k]) * W2'(md[k]);
            add_s[k] = (W+1)'(r_base[k]) + (W+1)'($signed(d[k]));
            if (add_s[k][W] != add_s[k][W-1]) begin
                add_c[k] = add_s[k][W] ? $signed(WHalfU) : $signed(WMaxU);
            end else begin
                add_c[k] = add_s[k][W-1:0];
            end
        end
    end

    // single wrap into [low, high), flag what stays outside
    always_comb begin
        s_e  = '0;
        lo_e = '0;
        hi_e = '0;
        t_e  = '0;
        wrap_on = r_ctl.drift && r_periodic;
        oob     = 1'b0;
        for (int k = 0; k < AXES; k++) begin
            s_e  = (W+2)'(r_sum[k]);
            lo_e = (W+2)'(r_box_low[k]);
            hi_e = (W+2)'(r_box_high[k]);
            if (s_e >= hi_e) begin
                t_e = s_e - r_span[k];
            end else if (s_e < lo_e) begin
                t_e = s_e + r_span[k];
            end else begin
                t_e = s_e;
            end
            if (t_e > EMax) begin
                p_w[k] = $signed(WMaxU);
            end else if (t_e < EMin) begin
                p_w[k] = $signed(WHalfU);
            end else begin
                p_w[k] = t_e[W-1:0];
            end
            if (r_empty[k]) begin
                p_w[k]     = r_sum[k];
                outside[k] = 1'b1;
            end else begin
                outside[k] = (p_w[k] < r_box_low[k]) || (p_w[k] >= r_box_high[k]);
            end
            res[k] = wrap_on ? p_w[k] : r_sum[k];
            oob    = oob | (wrap_on & outside[k]);
        end
    end

    always_comb begin
        sq_sum  = ExtBits'(r_sq[0]) + ExtBits'(r_sq[1]) + ExtBits'(r_sq[2]);
        sq64    = (|(sq_sum >> SQ_BITS)) ? '1 : sq_sum[SQ_BITS-1:0];
        max_new = (sq64 > r_max) ? sq64 : r_max;
    end

    // one result bit per step, two radicand bits in
    always_comb begin
        rem_t    = {r_rem, r_rad[SQ_BITS-1 -: 2]};
        trial    = {2'b00, r_root, 2'b01};
        root_ge  = (rem_t >= trial);
        root_ext = ExtR'(r_root);
        root_out = (|(root_ext >> W)) ? '1 : root_ext[W-1:0];
    end

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_MUL:  if (i_q_valid) n_state = S_SQ;
            S_SQ:   n_state = S_FIN;
            S_FIN: begin
                if (r_ctl.last) begin
                    n_state = S_ROOT;
                end else if (out_free) begin
                    n_state = S_MUL;
                end
            end
            S_ROOT: if (r_rdone && out_free) n_state = S_MUL;
            default: n_state = S_MUL;
        endcase
    end

    always_comb begin
        q_pop     = 1'b0;
        fin_emit  = 1'b0;
        fin_root  = 1'b0;
        root_step = 1'b0;
        root_emit = 1'b0;
        case (r_state)
            S_MUL: q_pop = i_q_valid;
            S_SQ: ;
            S_FIN: begin
                fin_root = r_ctl.last;
                fin_emit = !r_ctl.last && out_free;
            end
            S_ROOT: begin
                root_step = !r_rdone;
                root_emit = r_rdone && out_free;
            end
            default: ;
        endcase
    end

    assign o_q_pop = q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_MUL;
            r_max       <= '0;
            r_rdone     <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_emit) begin
                r_max <= max_new;
            end else if (fin_root) begin
                r_max <= '0;
            end
            if (fin_root) begin
                r_cnt   <= '0;
                r_rdone <= 1'b0;
            end else if (root_step) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ROOT_CNT_BITS'(ROOT_BITS - 1)) begin
                    r_rdone <= 1'b1;
                end
            end
            if (fin_emit || root_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_pop) begin
            r_ctl <= i_q_ctl;
            for (int k = 0; k < AXES; k++) begin
                r_p[k]    <= prod[k];
                r_base[k] <= q_base[k];
                r_neg[k]  <= q_neg[k] ^ r_sneg;
            end
        end
        if (r_state == S_SQ) begin
            for (int k = 0; k < AXES; k++) begin
                r_sq[k]  <= md_sq[k];
                r_sum[k] <= add_c[k];
            end
        end
        if (fin_root) begin
            r_res  <= res;
            r_roob <= oob;
            r_rad  <= max_new;
            r_rem  <= '0;
            r_root <= '0;
        end else if (root_step) begin
            r_rad  <= r_rad << 2;
            r_rem  <= root_ge ? (ROOT_BITS+2)'(rem_t - trial) : (ROOT_BITS+2)'(rem_t);
            r_root <= {r_root[ROOT_BITS-2:0], root_ge};
        end
        if (fin_emit) begin
            for (int k = 0; k < AXES; k++) begin
                r_out_new[k] <= res[k];
            end
            r_out_max  <= '0;
            r_out_last <= 1'b0;
            r_out_oob  <= oob;
        end else if (root_emit) begin
            for (int k = 0; k < AXES; k++) begin
                r_out_new[k] <= r_res[k];
            end
            r_out_max  <= root_out;
            r_out_last <= 1'b1;
            r_out_oob  <= r_roob;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_BITS'({r_out_max, r_out_new[2], r_out_new[1], r_out_new[0]});
    assign o_m_tuser  = r_out_oob;
    assign o_m_tlast  = r_out_last;

    a_root_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !r_ctl.last) |=> (r_state != S_ROOT))
        else $error("square root started for a particle that is not last");

    a_max_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT) |-> (r_max == '0))
        else $error("largest squared step not cleared at end of pass");

endmodule

// ===== rtl/particle_kick_drift_periodic.sv =====
// A kick or drift word passes from the queue through the multiply, square and wrap states of the back end
// into the output register; the last word of a pass then also runs the bit-serial square root.
// The back end takes the next word from the queue only once the last one has been emitted, and it
// holds a word in the wrap state, or a last word in the root, while the output register is full.
// Reset (synchronous, active low) empties the queue and output, restores the register defaults
// and clears the largest squared step; no clearing pass.
module particle_kick_drift_periodic #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_cfg_valid,
    output logic                                              o_cfg_ready,
    input  logic [pkdp_pkg::CFG_IDX_BITS-1:0]                 i_cfg_index,
    input  logic [WORD_BITS-1:0]                              i_cfg_data,
    input  logic                                              i_s_tvalid,
    output logic                                              o_s_tready,
    input  logic [((9*WORD_BITS+7)/8)*8-1:0]                  i_s_tdata,  // pos_x,y,z, vel_x,y,z, acc_x,y,z
    input  logic                                              i_s_tuser,  // operation
    input  logic                                              i_s_tlast,  // last_particle
    output logic                                              o_m_tvalid,
    input  logic                                              i_m_tready,
    output logic [((4*WORD_BITS+7)/8)*8-1:0]                  o_m_tdata,  // new_x,y,z, max_step
    output logic                                              o_m_tuser,  // out_of_box
    output logic                                              o_m_tlast   // pass_done
);
    import pkdp_pkg::*;

    localparam int InBits   = ((9 * WORD_BITS + 7) / 8) * 8;
    localparam int OutBits  = ((4 * WORD_BITS + 7) / 8) * 8;
    localparam int PayBits  = 2 * AXES * WORD_BITS + AXES;
    localparam int CtlBits  = $bits(t_item_ctl);
    localparam int QBits    = PayBits + CtlBits;

    logic               push;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    t_item_ctl          f_ctl;
    t_item_ctl          q_ctl;
    logic [PayBits-1:0] f_payload;
    logic [QBits-1:0]   q_data;

    pkdp_front #(
        .WORD_BITS (WORD_BITS),
        .IN_BITS   (InBits),
        .PAY_BITS  (PayBits)
    ) u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_ctl      (f_ctl),
        .o_payload  (f_payload)
    );

    pkdp_queue #(
        .DATA_BITS (QBits)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_ctl, f_payload}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    assign q_ctl = t_item_ctl'(q_data[QBits-1 -: CtlBits]);

    pkdp_back #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .PAY_BITS  (PayBits),
        .OUT_BITS  (OutBits)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_ctl     (q_ctl),
        .i_q_payload (q_data[PayBits-1:0]),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
